/* hw/rtl/qau_pkg.sv */
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, command codes and helpers of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

	typedef enum logic [2:0] {
		CMD_MUL   = 3'd0,
		CMD_CONJ  = 3'd1,
		CMD_ROT   = 3'd2,
		CMD_NORM  = 3'd3,
		CMD_BLEND = 3'd4,
		CMD_MAG   = 3'd5
	} cmd_t;

	localparam int          NORM_GUARD = 15;
	localparam int          SQRT_N     = 32;
	localparam int          SQRT_W     = 2 * SQRT_N;
	localparam int          SAT_W      = 40;
	localparam logic [16:0] BLEND_ONE  = 17'd65536;

	// operation class set by the front end
	typedef struct packed {
		logic ham;
		logic conj;
		logic norm;
		logic blend;
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		logic [3:0][16:0] p;
		logic [3:0][16:0] q;
		logic [16:0]      t;
		logic [16:0]      u;
	} item_t;

	// carried alongside the square roots
	typedef struct packed {
		op_t              op;
		logic [3:0][15:0] rq;
		logic [3:0]       neg;
		logic [3:0][15:0] absv;
		logic             zero;
	} sq_side_t;

	// carried alongside the dividers
	typedef struct packed {
		op_t              op;
		logic [3:0][15:0] rq;
		logic [3:0]       neg;
		logic             zero;
		logic [15:0]      norm;
	} dv_side_t;

	function automatic logic [15:0] sat_s16(input logic signed [SAT_W-1:0] v);
		logic [15:0] r;
		if (v > 40'sd32767) begin
			r = 16'h7FFF;
		end else if (v < -40'sd32768) begin
			r = 16'h8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

/* hw/rtl/qau_front.sv */
// ----------------------------------------------------------------------------
// qau_front
// Input register: decodes the command, forms product operands, clamps t.
// ----------------------------------------------------------------------------
module qau_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic signed [15:0]  a_w,
	input  logic signed [15:0]  a_x,
	input  logic signed [15:0]  a_y,
	input  logic signed [15:0]  a_z,
	input  logic signed [15:0]  b_w,
	input  logic signed [15:0]  b_x,
	input  logic signed [15:0]  b_y,
	input  logic signed [15:0]  b_z,
	input  logic [16:0]         blend,
	input  logic                q_full,
	output logic                push,
	output qau_pkg::item_t      item
);

	logic           valid_q;
	qau_pkg::item_t item_q;
	qau_pkg::item_t dec;
	logic           load;

	assign in_stall = valid_q && q_full;
	assign push     = valid_q && !q_full;
	assign load     = in_valid && !in_stall;
	assign item     = item_q;

	always_comb begin
		dec      = '0;
		dec.a    = {a_z, a_y, a_x, a_w};
		dec.b    = {b_z, b_y, b_x, b_w};
		dec.p[0] = 17'(a_w);
		dec.p[1] = 17'(a_x);
		dec.p[2] = 17'(a_y);
		dec.p[3] = 17'(a_z);
		dec.q[0] = 17'(b_w);
		dec.q[1] = 17'(b_x);
		dec.q[2] = 17'(b_y);
		dec.q[3] = 17'(b_z);
		dec.t    = (blend > qau_pkg::BLEND_ONE) ? qau_pkg::BLEND_ONE : blend;
		dec.u    = qau_pkg::BLEND_ONE - dec.t;
		case (qau_pkg::cmd_t'(command))
			qau_pkg::CMD_MUL: begin
				dec.op.ham = 1'b1;
			end
			qau_pkg::CMD_ROT: begin
				// b * conj(a), conj kept at 17 bits
				dec.op.ham = 1'b1;
				dec.p[0]   = 17'(b_w);
				dec.p[1]   = 17'(b_x);
				dec.p[2]   = 17'(b_y);
				dec.p[3]   = 17'(b_z);
				dec.q[0]   = 17'(a_w);
				dec.q[1]   = -17'(a_x);
				dec.q[2]   = -17'(a_y);
				dec.q[3]   = -17'(a_z);
			end
			qau_pkg::CMD_CONJ: begin
				dec.op.conj = 1'b1;
			end
			qau_pkg::CMD_NORM: begin
				dec.op.norm = 1'b1;
			end
			qau_pkg::CMD_BLEND: begin
				dec.op.norm  = 1'b1;
				dec.op.blend = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (push) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= dec;
		end
	end

endmodule

/* hw/rtl/qau_fifo.sv */
// ----------------------------------------------------------------------------
// qau_fifo
// Short queue between the front end and the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qau_fifo #(
	parameter int DEPTH = 4,
	parameter int WIDTH = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [WIDTH-1:0]             wdata,
	input  logic                         pop,
	output logic [WIDTH-1:0]             rdata,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	function automatic logic [PW-1:0] wrap(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wrap(wr_q);
			end
			if (do_pop) begin
				rd_q <= wrap(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

/* hw/rtl/qau_sqrt.sv */
// ----------------------------------------------------------------------------
// qau_sqrt
// Two-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qau_sqrt #(
	parameter int N    = 32,
	parameter int SB_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [1:0][2*N-1:0]    rad,
	input  logic [SB_W-1:0]        side_in,
	output logic                   out_valid,
	output logic [1:0][N-1:0]      root,
	output logic [1:0][N:0]        rem,
	output logic [SB_W-1:0]        side_out
);

	localparam int W = 2 * N;

	logic                valid_q [N];
	logic [SB_W-1:0]     side_q  [N];
	logic [1:0][W-1:0]   rem_q   [N];
	logic [1:0][W-1:0]   root_q  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (W - 2 - 2 * k);
		logic                v_i;
		logic [SB_W-1:0]     s_i;
		logic [1:0][W-1:0]   rem_i;
		logic [1:0][W-1:0]   root_i;
		logic [1:0][W-1:0]   rem_o;
		logic [1:0][W-1:0]   root_o;
		logic [1:0][W-1:0]   trial;

		if (k == 0) begin : g_first
			assign v_i    = in_valid;
			assign s_i    = side_in;
			assign rem_i  = rad;
			assign root_i = '0;
		end else begin : g_next
			assign v_i    = valid_q[k-1];
			assign s_i    = side_q[k-1];
			assign rem_i  = rem_q[k-1];
			assign root_i = root_q[k-1];
		end

		always_comb begin
			for (int l = 0; l < 2; l++) begin
				trial[l] = root_i[l] + BIT;
				if (rem_i[l] >= trial[l]) begin
					rem_o[l]  = rem_i[l] - trial[l];
					root_o[l] = (root_i[l] >> 1) + BIT;
				end else begin
					rem_o[l]  = rem_i[l];
					root_o[l] = root_i[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[k] <= 1'b0;
			end else if (en) begin
				valid_q[k] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[k] <= s_i;
				rem_q[k]  <= rem_o;
				root_q[k] <= root_o;
			end
		end
	end

	assign out_valid = valid_q[N-1];
	assign side_out  = side_q[N-1];
	assign root[0]   = root_q[N-1][0][N-1:0];
	assign root[1]   = root_q[N-1][1][N-1:0];
	assign rem[0]    = rem_q[N-1][0][N:0];
	assign rem[1]    = rem_q[N-1][1][N:0];

endmodule

/* hw/rtl/qau_div.sv */
// ----------------------------------------------------------------------------
// qau_div
// Four-lane pipelined restoring divider with a shared divisor.
// ----------------------------------------------------------------------------
module qau_div #(
	parameter int QW   = 15,
	parameter int VW   = 32,
	parameter int DW   = 46,
	parameter int SB_W = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [3:0][DW-1:0]   dvd,
	input  logic [VW-1:0]        dvs,
	input  logic [SB_W-1:0]      side_in,
	output logic                 out_valid,
	output logic [3:0][QW-1:0]   quo,
	output logic [SB_W-1:0]      side_out
);

	logic                valid_q [QW];
	logic [SB_W-1:0]     side_q  [QW];
	logic [VW-1:0]       dvs_q   [QW];
	logic [3:0][DW-1:0]  rem_q   [QW];
	logic [3:0][QW-1:0]  quo_q   [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int K = QW - 1 - j;
		logic                v_i;
		logic [SB_W-1:0]     s_i;
		logic [VW-1:0]       d_i;
		logic [3:0][DW-1:0]  rem_i;
		logic [3:0][QW-1:0]  quo_i;
		logic [3:0][DW-1:0]  rem_o;
		logic [3:0][QW-1:0]  quo_o;
		logic [DW-1:0]       shifted;

		if (j == 0) begin : g_first
			assign v_i   = in_valid;
			assign s_i   = side_in;
			assign d_i   = dvs;
			assign rem_i = dvd;
			assign quo_i = '0;
		end else begin : g_next
			assign v_i   = valid_q[j-1];
			assign s_i   = side_q[j-1];
			assign d_i   = dvs_q[j-1];
			assign rem_i = rem_q[j-1];
			assign quo_i = quo_q[j-1];
		end

		assign shifted = DW'(d_i) << K;

		always_comb begin
			for (int l = 0; l < 4; l++) begin
				if (rem_i[l] >= shifted) begin
					rem_o[l] = rem_i[l] - shifted;
					quo_o[l] = quo_i[l] | (QW'(1) << K);
				end else begin
					rem_o[l] = rem_i[l];
					quo_o[l] = quo_i[l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[j] <= 1'b0;
			end else if (en) begin
				valid_q[j] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_q[j] <= s_i;
				dvs_q[j]  <= d_i;
				rem_q[j]  <= rem_o;
				quo_q[j]  <= quo_o;
			end
		end
	end

	assign out_valid = valid_q[QW-1];
	assign side_out  = side_q[QW-1];
	assign quo       = quo_q[QW-1];

endmodule

/* hw/rtl/qau_back.sv */
// ----------------------------------------------------------------------------
// qau_back
// Arithmetic pipeline: products, blend, square roots, division, output.
// ----------------------------------------------------------------------------
module qau_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  qau_pkg::item_t      item,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  r_w,
	output logic signed [15:0]  r_x,
	output logic signed [15:0]  r_y,
	output logic signed [15:0]  r_z,
	output logic [15:0]         norm_value,
	output logic                zero_error
);

	localparam int QW = FRAC_BITS + 1;
	localparam int VW = qau_pkg::SQRT_N;
	localparam int DW = FRAC_BITS + 32;
	localparam logic signed [36:0] HAM_HALF = 37'sd1 <<< (FRAC_BITS - 1);

	logic en;

	// stage 1: products
	logic                valid_s1;
	qau_pkg::op_t        op_s1;
	logic [3:0][15:0]    a_s1;
	logic signed [33:0]  prod_s1 [4][4];
	logic signed [33:0]  bla_s1  [4];
	logic signed [33:0]  blb_s1  [4];
	logic [30:0]         sqa_s1  [4];
	logic signed [31:0]  sqa_c   [4];

	// stage 2: sums
	logic                valid_s2;
	qau_pkg::op_t        op_s2;
	logic [3:0][15:0]    rq_s2;
	logic [3:0][16:0]    nv_s2;
	logic [32:0]         sa_s2;
	logic signed [36:0]  hs_c    [4];
	logic signed [36:0]  hr_c    [4];
	logic signed [34:0]  bs_c    [4];
	logic signed [34:0]  bsh_c   [4];
	logic [3:0][15:0]    rq_c;
	logic [3:0][16:0]    nv_c;

	// stage 3: squares of the vector to normalize
	logic                valid_s3;
	qau_pkg::op_t        op_s3;
	logic [3:0][15:0]    rq_s3;
	logic [3:0][16:0]    nv_s3;
	logic [32:0]         sa_s3;
	logic [30:0]         sqn_s3  [4];
	logic signed [33:0]  sqn_c   [4];

	// stage 4: radicands
	logic                         valid_s4;
	logic [1:0][qau_pkg::SQRT_W-1:0] rad_s4;
	qau_pkg::sq_side_t            sq_side_s4;
	logic [32:0]                  sn_c;
	logic [3:0][16:0]             absn_c;

	// square roots
	logic                         sq_valid;
	logic [1:0][VW-1:0]           sq_root;
	logic [1:0][VW:0]             sq_rem;
	qau_pkg::sq_side_t            sq_side;

	// stage 5: dividends
	logic                         valid_s5;
	logic [3:0][DW-1:0]           dvd_s5;
	logic [VW-1:0]                dvs_s5;
	qau_pkg::dv_side_t            dv_side_s5;
	logic [32:0]                  mag_c;

	// division
	logic                         dv_valid;
	logic [3:0][QW-1:0]           dv_quo;
	qau_pkg::dv_side_t            dv_side;

	// output register
	logic                         out_valid_q;
	logic [3:0][15:0]             r_q;
	logic [15:0]                  norm_q;
	logic                         zerr_q;
	logic [3:0][15:0]             nres_c;
	logic [31:0]                  q32_c   [4];

	assign en  = !(out_valid_q && out_stall);
	assign pop = en && in_valid;

	// ---------------- stage 1 ----------------
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sqa_c[i] = $signed(item.a[i]) * $signed(item.a[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= item.op;
			a_s1  <= item.a;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_s1[i][j] <= $signed(item.p[i]) * $signed(item.q[j]);
				end
				bla_s1[i] <= $signed(item.a[i]) * $signed({1'b0, item.t});
				blb_s1[i] <= $signed(item.b[i]) * $signed({1'b0, item.u});
				sqa_s1[i] <= sqa_c[i][30:0];
			end
		end
	end

	// ---------------- stage 2 ----------------
	always_comb begin
		hs_c[0] = 37'(prod_s1[0][0]) - 37'(prod_s1[1][1]) - 37'(prod_s1[2][2])
			- 37'(prod_s1[3][3]);
		hs_c[1] = 37'(prod_s1[0][1]) + 37'(prod_s1[1][0]) + 37'(prod_s1[2][3])
			- 37'(prod_s1[3][2]);
		hs_c[2] = 37'(prod_s1[0][2]) - 37'(prod_s1[1][3]) + 37'(prod_s1[2][0])
			+ 37'(prod_s1[3][1]);
		hs_c[3] = 37'(prod_s1[0][3]) + 37'(prod_s1[1][2]) - 37'(prod_s1[2][1])
			+ 37'(prod_s1[3][0]);
		for (int i = 0; i < 4; i++) begin
			hr_c[i]  = (hs_c[i] + HAM_HALF) >>> FRAC_BITS;
			bs_c[i]  = 35'(bla_s1[i]) + 35'(blb_s1[i]) + 35'sd32768;
			bsh_c[i] = bs_c[i] >>> 16;
			if (op_s1.ham) begin
				rq_c[i] = qau_pkg::sat_s16(qau_pkg::SAT_W'(hr_c[i]));
			end else if (op_s1.conj) begin
				if (i == 0) begin
					rq_c[i] = a_s1[0];
				end else begin
					rq_c[i] = qau_pkg::sat_s16(-qau_pkg::SAT_W'($signed(a_s1[i])));
				end
			end else begin
				rq_c[i] = '0;
			end
			nv_c[i] = op_s1.blend ? bsh_c[i][16:0] : 17'($signed(a_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			rq_s2 <= rq_c;
			nv_s2 <= nv_c;
			sa_s2 <= 33'(sqa_s1[0]) + 33'(sqa_s1[1]) + 33'(sqa_s1[2]) + 33'(sqa_s1[3]);
		end
	end

	// ---------------- stage 3 ----------------
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sqn_c[i] = $signed(nv_s2[i]) * $signed(nv_s2[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			rq_s3 <= rq_s2;
			nv_s3 <= nv_s2;
			sa_s3 <= sa_s2;
			for (int i = 0; i < 4; i++) begin
				sqn_s3[i] <= sqn_c[i][30:0];
			end
		end
	end

	// ---------------- stage 4 ----------------
	always_comb begin
		sn_c = 33'(sqn_s3[0]) + 33'(sqn_s3[1]) + 33'(sqn_s3[2]) + 33'(sqn_s3[3]);
		for (int i = 0; i < 4; i++) begin
			absn_c[i] = nv_s3[i][16] ? -nv_s3[i] : nv_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4[0]       <= qau_pkg::SQRT_W'(sn_c) << (2 * qau_pkg::NORM_GUARD);
			rad_s4[1]       <= qau_pkg::SQRT_W'(sa_s3);
			sq_side_s4.op   <= op_s3;
			sq_side_s4.rq   <= rq_s3;
			sq_side_s4.zero <= (sn_c == '0);
			for (int i = 0; i < 4; i++) begin
				sq_side_s4.neg[i]  <= nv_s3[i][16];
				sq_side_s4.absv[i] <= absn_c[i][15:0];
			end
		end
	end

	qau_sqrt #(
		.N    (qau_pkg::SQRT_N),
		.SB_W ($bits(qau_pkg::sq_side_t))
	) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s4),
		.rad       (rad_s4),
		.side_in   (sq_side_s4),
		.out_valid (sq_valid),
		.root      (sq_root),
		.rem       (sq_rem),
		.side_out  (sq_side)
	);

	// ---------------- stage 5 ----------------
	// round the magnitude of a to nearest using the root remainder
	assign mag_c = 33'(sq_root[1]) + 33'(sq_rem[1][VW:0] > 33'(sq_root[1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvs_s5          <= sq_root[0];
			dv_side_s5.op   <= sq_side.op;
			dv_side_s5.rq   <= sq_side.rq;
			dv_side_s5.neg  <= sq_side.neg;
			dv_side_s5.zero <= sq_side.zero;
			dv_side_s5.norm <= (mag_c > 33'd65535) ? 16'hFFFF : mag_c[15:0];
			for (int i = 0; i < 4; i++) begin
				dvd_s5[i] <= (DW'(sq_side.absv[i]) << (FRAC_BITS + qau_pkg::NORM_GUARD))
					+ DW'(sq_root[0] >> 1);
			end
		end
	end

	qau_div #(
		.QW   (QW),
		.VW   (VW),
		.DW   (DW),
		.SB_W ($bits(qau_pkg::dv_side_t))
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s5),
		.dvd       (dvd_s5),
		.dvs       (dvs_s5),
		.side_in   (dv_side_s5),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.side_out  (dv_side)
	);

	// ---------------- output ----------------
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q32_c[i] = 32'(dv_quo[i]);
			if (dv_side.zero) begin
				nres_c[i] = '0;
			end else if (dv_side.neg[i]) begin
				nres_c[i] = (q32_c[i] > 32'd32768) ? 16'h8000 : 16'(-q32_c[i]);
			end else begin
				nres_c[i] = (q32_c[i] > 32'd32767) ? 16'h7FFF : q32_c[i][15:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_q    <= dv_side.op.norm ? nres_c : dv_side.rq;
			zerr_q <= dv_side.op.norm && dv_side.zero;
			norm_q <= dv_side.norm;
		end
	end

	assign out_valid  = out_valid_q;
	assign r_w        = $signed(r_q[0]);
	assign r_x        = $signed(r_q[1]);
	assign r_y        = $signed(r_q[2]);
	assign r_z        = $signed(r_q[3]);
	assign norm_value = norm_q;
	assign zero_error = zerr_q;

endmodule

/* hw/rtl/quaternion_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Fixed-point quaternion product, conjugate, rotation, normalize, blend and magnitude.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries command, quaternions a and b in
//   signed fixed point with FRAC_BITS fraction bits, and blend weight t in
//   Q1.16. A transfer happens on a clock edge with in_valid high and
//   in_stall low. Output channel out_valid/out_stall returns r_w..r_z,
//   norm_value (magnitude of a) and zero_error, one result per item, in order.
//   Throughput is one item per cycle while out_stall stays low. An item
//   passes an input register, the queue, four arithmetic stages, a
//   32-stage square root, one dividend stage, a FRAC_BITS + 1 stage divider
//   and the output register; the square root and divider are most of them.
//   While out_stall holds a waiting result, the arithmetic pipeline freezes;
//   the input register and QUEUE_DEPTH entries keep taking items until full,
//   then in_stall rises. Reset clears all valid state; no result is pending.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
	parameter int FRAC_BITS   = 14,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          command,
	input  logic signed [15:0]  a_w,
	input  logic signed [15:0]  a_x,
	input  logic signed [15:0]  a_y,
	input  logic signed [15:0]  a_z,
	input  logic signed [15:0]  b_w,
	input  logic signed [15:0]  b_x,
	input  logic signed [15:0]  b_y,
	input  logic signed [15:0]  b_z,
	input  logic [16:0]         blend,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  r_w,
	output logic signed [15:0]  r_x,
	output logic signed [15:0]  r_y,
	output logic signed [15:0]  r_z,
	output logic [15:0]         norm_value,
	output logic                zero_error
);

	qau_pkg::item_t                      front_item;
	qau_pkg::item_t                      q_item;
	logic                                q_push;
	logic                                q_pop;
	logic                                q_full;
	logic                                q_empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count;

	qau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.command  (command),
		.a_w      (a_w),
		.a_x      (a_x),
		.a_y      (a_y),
		.a_z      (a_z),
		.b_w      (b_w),
		.b_x      (b_x),
		.b_y      (b_y),
		.b_z      (b_z),
		.blend    (blend),
		.q_full   (q_full),
		.push     (q_push),
		.item     (front_item)
	);

	qau_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH ($bits(qau_pkg::item_t))
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (front_item),
		.pop    (q_pop),
		.rdata  (q_item),
		.full   (q_full),
		.empty  (q_empty),
		.count  (q_count)
	);

	qau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.item       (q_item),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.r_w        (r_w),
		.r_x        (r_x),
		.r_y        (r_y),
		.r_z        (r_z),
		.norm_value (norm_value),
		.zero_error (zero_error)
	);

	// a zero-length normalize always yields an all-zero quaternion
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_error |-> (r_w == 16'sd0 && r_x == 16'sd0 &&
			r_y == 16'sd0 && r_z == 16'sd0))
		else $error("zero_error with nonzero quaternion");

	// the front end only holds off while the queue is full
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> q_full)
		else $error("input stalled with room in queue");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quaternion arithmetic unit: a behavioral
// predictor computes product, conjugate, rotation, normalize, blend and
// magnitude per transfer, and a monitor compares every returned result.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int         FRAC        = 14;
	localparam int         GUARD       = 15;
	localparam int         LIMIT       = 300000;

	typedef struct packed {
		logic [2:0]       cmd;
		logic [3:0][15:0] a;
		logic [3:0][15:0] b;
		logic [16:0]      t;
	} quat_item_t;

	typedef struct packed {
		logic [3:0][15:0] r;
		logic [15:0]      mag;
		logic             zerr;
	} quat_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] command = '0;
	logic signed [15:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
	logic signed [15:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
	logic [16:0] blend = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] r_w, r_x, r_y, r_z;
	logic [15:0] norm_value;
	logic zero_error;

	quat_item_t   pending_items[$];
	quat_result_t expected_results[$];
	quat_item_t   on_bus;
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;

	quaternion_arithmetic_unit uut (.*);

	always #6 clk = ~clk;

	// ---------------- predictor ----------------
	function automatic longint round_shift(longint v, int s);
		longint half;
		half = longint'(1) << (s - 1);
		if (v >= 0)
			return (v + half) >>> s;
		return -(((-v) + half - 1) >>> s);
	endfunction

	function automatic longint sat16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned energy(longint q[4]);
		longint unsigned s;
		s = 0;
		for (int i = 0; i < 4; i++)
			s += longint'(q[i] * q[i]);
		return s;
	endfunction

	function automatic void hamilton(input longint p[4], input longint q[4],
			output logic [3:0][15:0] r);
		longint v[4];
		v[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
		v[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
		v[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
		v[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
		for (int i = 0; i < 4; i++)
			r[i] = 16'(sat16(round_shift(v[i], FRAC)));
	endfunction

	function automatic logic unit_scale(input longint q[4], output logic [3:0][15:0] r);
		longint unsigned s, m, mg, quo;
		longint v;
		s = energy(q);
		r = '0;
		if (s == 0)
			return 1'b1;
		m = root_floor(s << (2 * GUARD));
		for (int i = 0; i < 4; i++) begin
			mg = (q[i] < 0) ? -q[i] : q[i];
			quo = ((mg << (FRAC + GUARD)) + (m >> 1)) / m;
			v = (quo > 65536) ? 65536 : longint'(quo);
			r[i] = 16'(sat16((q[i] < 0) ? -v : v));
		end
		return 1'b0;
	endfunction

	function automatic quat_result_t quat_predict(quat_item_t it);
		quat_result_t res;
		longint a[4], b[4], c[4];
		longint unsigned t, s, mg;
		res = '0;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(it.a[i]));
			b[i] = longint'($signed(it.b[i]));
		end
		t = (it.t > qau_pkg::BLEND_ONE) ? 65536 : it.t;
		case (it.cmd)
			qau_pkg::CMD_MUL: hamilton(a, b, res.r);
			qau_pkg::CMD_CONJ: begin
				res.r[0] = 16'(sat16(a[0]));
				for (int i = 1; i < 4; i++)
					res.r[i] = 16'(sat16(-a[i]));
			end
			qau_pkg::CMD_ROT: begin
				c[0] = a[0];
				for (int i = 1; i < 4; i++)
					c[i] = -a[i];
				hamilton(b, c, res.r);
			end
			qau_pkg::CMD_NORM: res.zerr = unit_scale(a, res.r);
			qau_pkg::CMD_BLEND: begin
				for (int i = 0; i < 4; i++)
					c[i] = round_shift(a[i] * longint'(t) + b[i] * longint'(65536 - t), 16);
				res.zerr = unit_scale(c, res.r);
			end
			default: ;
		endcase
		s = energy(a);
		mg = root_floor(s);
		if (s - mg * mg > mg)
			mg++;
		res.mag = (mg > 65535) ? 16'hFFFF : 16'(mg);
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [15:0] pick16();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3, 4: return 16'($signed($urandom_range(32768)) - 16384);
			5: return 16'($signed($urandom_range(512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic quat_item_t random_item();
		quat_item_t it;
		it.cmd = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
		for (int i = 0; i < 4; i++) begin
			it.a[i] = pick16();
			it.b[i] = pick16();
		end
		if ($urandom_range(15) == 0)
			it.a = '0;
		case ($urandom_range(9))
			0: it.t = 17'($urandom);
			1: it.t = qau_pkg::BLEND_ONE;
			2: it.t = '0;
			default: it.t = 17'($urandom_range(65536));
		endcase
		return it;
	endfunction

	function automatic quat_item_t make_item(logic [2:0] cmd, logic [15:0] av,
			logic [15:0] bv, logic [16:0] t);
		quat_item_t it;
		it.cmd = cmd;
		it.a = {4{av}};
		it.b = {4{bv}};
		it.t = t;
		return it;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------- driver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				expected_results.push_back(quat_predict(on_bus));
			if (!in_valid || !in_stall) begin
				if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_items.pop_front();
					in_valid <= 1'b1;
					command <= on_bus.cmd;
					{a_w, a_x, a_y, a_z} <= {on_bus.a[0], on_bus.a[1], on_bus.a[2], on_bus.a[3]};
					{b_w, b_x, b_y, b_z} <= {on_bus.b[0], on_bus.b[1], on_bus.b[2], on_bus.b[3]};
					blend <= on_bus.t;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver ----------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		quat_result_t want;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report("unexpected transfer", 0, 0);
			end else begin
				want = expected_results.pop_front();
				if (r_w !== want.r[0]) report("r_w", r_w, $signed(want.r[0]));
				if (r_x !== want.r[1]) report("r_x", r_x, $signed(want.r[1]));
				if (r_y !== want.r[2]) report("r_y", r_y, $signed(want.r[2]));
				if (r_z !== want.r[3]) report("r_z", r_z, $signed(want.r[3]));
				if (norm_value !== want.mag) report("norm_value", norm_value, want.mag);
				if (zero_error !== want.zerr) report("zero_error", zero_error, want.zerr);
			end
		end
	end

	// ---------------- sequence ----------------
	initial begin
		quat_item_t it;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corners: every command at full-scale values, zero vectors, blend weights
		for (int c = 0; c < 8; c++) begin
			pending_items.push_back(make_item(3'(c), 16'h8000, 16'h8000, qau_pkg::BLEND_ONE));
			pending_items.push_back(make_item(3'(c), 16'h7FFF, 16'h8000, 17'h1FFFF));
		end
		pending_items.push_back(make_item(qau_pkg::CMD_NORM, 16'h0000, 16'h7FFF, '0));
		pending_items.push_back(make_item(qau_pkg::CMD_BLEND, 16'h0000, 16'h0000, 17'd32768));
		pending_items.push_back(make_item(qau_pkg::CMD_BLEND, 16'h4000, 16'h0000, '0));
		pending_items.push_back(make_item(qau_pkg::CMD_BLEND, 16'h4000, 16'hC000, 17'd32768));
		pending_items.push_back(make_item(qau_pkg::CMD_BLEND, 16'h8000, 16'h7FFF, 17'd65537));
		pending_items.push_back(make_item(qau_pkg::CMD_CONJ, 16'h8000, 16'h0000, '0));
		pending_items.push_back(make_item(qau_pkg::CMD_MAG, 16'h0001, 16'hFFFF, 17'd1));
		pending_items.push_back(make_item(qau_pkg::CMD_ROT, 16'h4000, 16'h2D41, 17'd1));
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 77 : 0;
			recv_idle_pct = (ph == 0) ? 77 : (ph == 1) ? 7 : 0;
			if (ph == 2)
				hold_req = 1;
			for (int n = 0; n < 510; n++) begin
				it = random_item();
				pending_items.push_back(it);
			end
			// sender pauses here until every result is back
			drain();
		end
		repeat (80) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
